@@ rtl/oct_pkg.sv @@
// ----------------------------------------------------------------------------
// oct_pkg
// Shared types and constants for the oven cook timer controller.
// ----------------------------------------------------------------------------
`default_nettype none

package oct_pkg;

	localparam int LED_COUNT        = 8;
	localparam int ADC_BITS         = 10;
	localparam int LED_IDX_W        = $clog2(LED_COUNT);
	localparam int TICKS_PER_SECOND = 5;

	localparam logic [9:0] TEMP_RESET    = 10'd350;
	localparam logic [9:0] BROIL_DEGREES = 10'd500;
	localparam logic [7:0] HOLD_RESET    = 8'd5;
	localparam logic [8:0] OFFSET_RESET  = 9'd300;

	localparam logic [LED_COUNT-1:0] LED_MASK = {LED_COUNT{1'b1}};

	// register indexes of the configuration port
	localparam logic [1:0] REG_HOLD_TICKS  = 2'd0;
	localparam logic [1:0] REG_TEMP_OFFSET = 2'd1;

	// encoded state as shown on the result
	localparam logic [2:0] CODE_SETUP  = 3'd0;
	localparam logic [2:0] CODE_SELECT = 3'd1;
	localparam logic [2:0] CODE_COOK   = 3'd2;
	localparam logic [2:0] CODE_RESETP = 3'd3;
	localparam logic [2:0] CODE_ALERT  = 3'd4;

	localparam logic [1:0] MODE_BAKE  = 2'd0;
	localparam logic [1:0] MODE_BROIL = 2'd2;

	typedef enum logic [4:0] {
		ST_SETUP  = 5'b00001,
		ST_SELECT = 5'b00010,
		ST_COOK   = 5'b00100,
		ST_RESETP = 5'b01000,
		ST_ALERT  = 5'b10000
	} oven_state_t;

	typedef struct packed {
		logic       tick;
		logic       adc_valid;
		logic [9:0] adc_value;
		logic       btn3_down;
		logic       btn3_up;
		logic       btn4_down;
		logic       btn4_up;
	} event_item_t;

	typedef struct packed {
		logic [2:0] oven_state_out;
		logic [1:0] mode_out;
		logic [9:0] temperature_out;
		logic [8:0] cook_time_out;
		logic [8:0] time_left_out;
		logic       editing_temp;
		logic [7:0] led_bar;
		logic       heater_on;
		logic       display_inverted;
	} status_item_t;

	typedef struct packed {
		logic [7:0] hold_ticks;
		logic [8:0] temp_offset;
	} oct_cfg_t;

	function automatic logic [2:0] state_code(input oven_state_t st);
		logic [2:0] code;
		unique case (st)
			ST_SETUP:  code = CODE_SETUP;
			ST_SELECT: code = CODE_SELECT;
			ST_COOK:   code = CODE_COOK;
			ST_RESETP: code = CODE_RESETP;
			ST_ALERT:  code = CODE_ALERT;
			default:   code = CODE_SETUP;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

@@ rtl/oct_core.sv @@
// ----------------------------------------------------------------------------
// oct_core
// Oven state, settings and progress bar; one event request per step.
// ----------------------------------------------------------------------------
`default_nettype none

module oct_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  oct_pkg::event_item_t  item,
	input  oct_pkg::oct_cfg_t     cfg,
	output oct_pkg::status_item_t result
);

	oct_pkg::oven_state_t state_q, state_n;

	logic [15:0] running_q, running_n;
	logic [1:0]  mode_q, mode_n;
	logic [9:0]  temp_q, temp_n;
	logic [9:0]  saved_temp_q, saved_temp_n;
	logic [8:0]  cook_time_q, cook_time_n;
	logic [8:0]  time_left_q, time_left_n;
	logic [15:0] stamp_q, stamp_n;
	logic [2:0]  phase_q, phase_n;
	logic [oct_pkg::LED_COUNT-1:0] pattern_q, pattern_n;
	logic [11:0] period_q, period_n;
	logic [oct_pkg::LED_IDX_W-1:0] extra_q, extra_n;
	logic [11:0] count_q, count_n;
	logic        temp_edit_q, temp_edit_n;
	logic        normal_q, normal_n;

	// helper values
	logic [15:0] held;
	logic        hold_met;
	logic [7:0]  knob;
	logic        knob_to_temp;
	logic [8:0]  setup_cook_time;
	logic [11:0] cook_ticks;
	logic [1:0]  mode_next;

	// progress bar advance for one tick
	logic [11:0] lt_count;
	logic        lt_shift;
	logic [oct_pkg::LED_COUNT-1:0] lt_pattern;
	logic [oct_pkg::LED_IDX_W-1:0] lt_extra;
	logic [2:0]  lt_phase;

	assign running_n    = item.tick ? running_q + 16'd1 : running_q;
	assign held         = running_n - stamp_q;
	assign hold_met     = held >= {8'd0, cfg.hold_ticks};
	assign knob         = item.adc_value[oct_pkg::ADC_BITS-1 -: 8];
	assign knob_to_temp = (mode_q == oct_pkg::MODE_BAKE) && temp_edit_q;
	assign setup_cook_time = (item.adc_valid && !knob_to_temp) ? {1'b0, knob} + 9'd1
		: cook_time_q;
	assign cook_ticks   = 12'(setup_cook_time) * 12'(oct_pkg::TICKS_PER_SECOND);
	assign mode_next    = (mode_q >= oct_pkg::MODE_BROIL) ? oct_pkg::MODE_BAKE
		: mode_q + 2'd1;

	assign lt_count = count_q + 12'd1;
	assign lt_shift = (extra_q != '0) ? ({1'b0, lt_count} == {1'b0, period_q} + 13'd1)
		: (lt_count == period_q);
	assign lt_pattern = lt_shift ? {pattern_q[oct_pkg::LED_COUNT-2:0], 1'b0} : pattern_q;
	assign lt_extra   = (lt_shift && extra_q != '0) ? extra_q - oct_pkg::LED_IDX_W'(1)
		: extra_q;
	assign lt_phase   = (phase_q == 3'(oct_pkg::TICKS_PER_SECOND - 1)) ? 3'd0
		: phase_q + 3'd1;

	always_comb begin
		state_n      = state_q;
		mode_n       = mode_q;
		temp_n       = temp_q;
		saved_temp_n = saved_temp_q;
		cook_time_n  = cook_time_q;
		time_left_n  = time_left_q;
		stamp_n      = stamp_q;
		phase_n      = phase_q;
		pattern_n    = pattern_q;
		period_n     = period_q;
		extra_n      = extra_q;
		count_n      = count_q;
		temp_edit_n  = temp_edit_q;
		normal_n     = normal_q;
		unique case (state_q)
			oct_pkg::ST_RESETP: begin
				if (item.tick) begin
					count_n   = lt_shift ? 12'd0 : lt_count;
					pattern_n = lt_pattern;
					extra_n   = lt_extra;
					phase_n   = lt_phase;
					if (hold_met) begin
						time_left_n = cook_time_q;
						state_n     = oct_pkg::ST_SETUP;
						pattern_n   = '0;
					end
				end
				// early release goes back to cooking
				if (item.btn4_up && !hold_met) begin
					state_n = oct_pkg::ST_COOK;
				end
			end
			oct_pkg::ST_COOK: begin
				if (item.tick && time_left_q == 9'd0) begin
					count_n     = lt_shift ? 12'd0 : lt_count;
					extra_n     = lt_extra;
					phase_n     = lt_phase;
					time_left_n = cook_time_q;
					state_n     = oct_pkg::ST_ALERT;
					pattern_n   = '0;
				end else begin
					if (item.tick) begin
						count_n   = lt_shift ? 12'd0 : lt_count;
						pattern_n = lt_pattern;
						extra_n   = lt_extra;
						phase_n   = lt_phase;
						if (lt_phase == 3'd0) begin
							time_left_n = time_left_q - 9'd1;
						end
					end
					if (item.btn4_down) begin
						state_n = oct_pkg::ST_RESETP;
						stamp_n = running_n;
					end
				end
			end
			oct_pkg::ST_SELECT: begin
				if (item.btn3_up) begin
					if (hold_met && mode_q == oct_pkg::MODE_BAKE) begin
						temp_edit_n = !temp_edit_q;
					end else begin
						mode_n = mode_next;
						if (mode_next == oct_pkg::MODE_BROIL) begin
							if (temp_edit_q) begin
								temp_n = oct_pkg::BROIL_DEGREES;
							end else begin
								saved_temp_n = temp_q;
							end
						end
					end
					state_n = oct_pkg::ST_SETUP;
				end
			end
			oct_pkg::ST_SETUP: begin
				if (item.adc_valid) begin
					if (knob_to_temp) begin
						temp_n = {2'd0, knob} + {1'b0, cfg.temp_offset};
					end else begin
						cook_time_n = setup_cook_time;
						time_left_n = setup_cook_time;
					end
				end
				if (item.btn3_down) begin
					stamp_n = running_n;
					state_n = oct_pkg::ST_SELECT;
				end else if (item.btn4_down) begin
					phase_n   = 3'd0;
					state_n   = oct_pkg::ST_COOK;
					pattern_n = oct_pkg::LED_MASK;
					period_n  = 12'(cook_ticks / oct_pkg::LED_COUNT);
					extra_n   = oct_pkg::LED_IDX_W'(cook_ticks % oct_pkg::LED_COUNT);
					count_n   = 12'd0;
				end
			end
			oct_pkg::ST_ALERT: begin
				if (item.tick) begin
					normal_n = !normal_q;
				end
				if (item.btn4_up) begin
					normal_n = 1'b1;
					state_n  = oct_pkg::ST_SETUP;
				end
			end
			default: begin
				state_n = oct_pkg::ST_SETUP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= oct_pkg::ST_SETUP;
			running_q    <= '0;
			mode_q       <= oct_pkg::MODE_BAKE;
			temp_q       <= oct_pkg::TEMP_RESET;
			saved_temp_q <= '0;
			cook_time_q  <= 9'd1;
			time_left_q  <= 9'd1;
			stamp_q      <= '0;
			phase_q      <= '0;
			pattern_q    <= '0;
			period_q     <= '0;
			extra_q      <= '0;
			count_q      <= '0;
			temp_edit_q  <= 1'b0;
			normal_q     <= 1'b0;
		end else if (step) begin
			state_q      <= state_n;
			running_q    <= running_n;
			mode_q       <= mode_n;
			temp_q       <= temp_n;
			saved_temp_q <= saved_temp_n;
			cook_time_q  <= cook_time_n;
			time_left_q  <= time_left_n;
			stamp_q      <= stamp_n;
			phase_q      <= phase_n;
			pattern_q    <= pattern_n;
			period_q     <= period_n;
			extra_q      <= extra_n;
			count_q      <= count_n;
			temp_edit_q  <= temp_edit_n;
			normal_q     <= normal_n;
		end
	end

	always_comb begin
		result.oven_state_out   = oct_pkg::state_code(state_n);
		result.mode_out         = mode_n;
		result.temperature_out  = temp_n;
		result.cook_time_out    = cook_time_n;
		result.time_left_out    = time_left_n;
		result.editing_temp     = temp_edit_n;
		result.led_bar          = 8'(pattern_n);
		result.heater_on        = (state_n == oct_pkg::ST_COOK) ||
			(state_n == oct_pkg::ST_RESETP);
		result.display_inverted = (state_n == oct_pkg::ST_ALERT) && !normal_n;
	end

endmodule

`default_nettype wire

@@ rtl/oven_cook_timer_controller.sv @@
// ----------------------------------------------------------------------------
// oven_cook_timer_controller
// Toaster-oven cook timer: event requests in, one status request out per event.
// ----------------------------------------------------------------------------
// Each accepted event request yields exactly one status request: the event is
// held in the input register while the state update runs, and the result is
// caught in the output register. A new event can be taken every cycle; the only
// limit is the output register, which holds while status_stall is high and then
// stalls the input side once the input register is also full. Configuration
// writes are always ready and should be made while no request is in flight.
`default_nettype none

module oven_cook_timer_controller (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   event_valid,
	output logic                  event_stall,
	input  oct_pkg::event_item_t  event_item,
	output logic                  status_valid,
	input  wire                   status_stall,
	output oct_pkg::status_item_t status_item,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [1:0]            cfg_index,
	input  wire  [8:0]            cfg_data
);

	oct_pkg::oct_cfg_t     cfg_q;
	oct_pkg::event_item_t  item_s1;
	oct_pkg::status_item_t result;
	logic                  valid_s1;
	logic                  out_free;
	logic                  advance;
	logic                  take;

	assign cfg_ready   = 1'b1;
	assign out_free    = !status_valid || !status_stall;
	assign advance     = valid_s1 && out_free;
	assign event_stall = valid_s1 && !out_free;
	assign take        = event_valid && !event_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks  <= oct_pkg::HOLD_RESET;
			cfg_q.temp_offset <= oct_pkg::OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				oct_pkg::REG_HOLD_TICKS:  cfg_q.hold_ticks  <= cfg_data[7:0];
				oct_pkg::REG_TEMP_OFFSET: cfg_q.temp_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= event_item;
		end
	end

	oct_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid <= 1'b0;
		end else if (out_free) begin
			status_valid <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_item <= result;
		end
	end

endmodule

`default_nettype wire

@@ rtl/oct_checker.sv @@
// ----------------------------------------------------------------------------
// oct_checker
// Port-level checks on the status requests of the oven cook timer controller.
// ----------------------------------------------------------------------------
`default_nettype none

module oct_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   status_valid,
	input wire                   status_stall,
	input oct_pkg::status_item_t status_item
);

	// a stalled status request holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_stall |=> status_valid && $stable(status_item))
		else $error("status request changed while stalled");

	a_heater: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status_item.heater_on ==
			((status_item.oven_state_out == oct_pkg::CODE_COOK) ||
			(status_item.oven_state_out == oct_pkg::CODE_RESETP)))
		else $error("heater does not follow the oven state");

	a_invert: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_item.display_inverted |->
			status_item.oven_state_out == oct_pkg::CODE_ALERT)
		else $error("display inverted outside alert");

	// bar is dark unless cooking or waiting on a reset hold
	a_bar_dark: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && (status_item.oven_state_out == oct_pkg::CODE_SETUP ||
			status_item.oven_state_out == oct_pkg::CODE_SELECT ||
			status_item.oven_state_out == oct_pkg::CODE_ALERT) |->
			status_item.led_bar == 8'd0)
		else $error("progress bar lit while not cooking");

	a_time_left: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status_item.time_left_out <= status_item.cook_time_out)
		else $error("time left exceeds cook time");

endmodule

bind oven_cook_timer_controller oct_checker u_oct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.status_valid (status_valid),
	.status_stall (status_stall),
	.status_item  (status_item)
);

`default_nettype wire
